// ----- sv/ascii_coordinate_packet_parser_top_macros.svh -----
// Assertion macros for the ASCII coordinate frame parser.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef ASCII_COORDINATE_PACKET_PARSER_TOP_MACROS_SVH
`define ASCII_COORDINATE_PACKET_PARSER_TOP_MACROS_SVH

`ifndef SYNTH

// prop must hold at every clock edge outside reset
`define ACPP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("acpp check failed");

// cond must never be true outside reset
`define ACPP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("acpp forbidden condition seen");

`else

`define ACPP_ASSERT(lbl, clk, rst_n, prop)
`define ACPP_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- sv/acpp_pkg.sv -----
// Shared types and constants of the ASCII coordinate frame parser.
// No dependencies; imported by every module and interface of the block.
`default_nettype none

package acpp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ValW  = 32;
  localparam int unsigned KindW = 2;

  localparam logic [ByteW-1:0] CH_START = 8'h24;  // '$'
  localparam logic [ByteW-1:0] CH_END   = 8'h23;  // '#'
  localparam logic [ByteW-1:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [ByteW-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [ByteW-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [ByteW-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [ByteW-1:0] TYPE_O   = 8'h4F;
  localparam logic [ByteW-1:0] TYPE_L   = 8'h4C;
  localparam logic [ByteW-1:0] TYPE_C   = 8'h43;

  // body bytes needed between the marks
  localparam logic [1:0] MIN_BODY = 2'd3;

  localparam logic [KindW-1:0] KIND_CIRCLE = 2'd0;
  localparam logic [KindW-1:0] KIND_LASER  = 2'd1;
  localparam logic [KindW-1:0] KIND_CROSS  = 2'd2;
  localparam logic [KindW-1:0] KIND_NONE   = 2'd3;

  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_SKIP   = 3'd1,
    PH_XSTART = 3'd2,
    PH_XDIG   = 3'd3,
    PH_YSTART = 3'd5,
    PH_YDIG   = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [KindW-1:0]       kind;
    logic signed [ValW-1:0] x;
    logic signed [ValW-1:0] y;
  } result_t;

  function automatic logic signed [ValW-1:0] trunc16(input logic signed [ValW-1:0] v);
    trunc16 = {{(ValW-16){v[15]}}, v[15:0]};
  endfunction

endpackage

`default_nettype wire

// ----- sv/acpp_if.sv -----
// Valid/ready channel interfaces for the received-byte and result words.
// Depends on acpp_pkg for the field widths.
`default_nettype none

interface acpp_in_if
  import acpp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface acpp_out_if
  import acpp_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [KindW-1:0]       target_kind;
  logic signed [ValW-1:0] x_value;
  logic signed [ValW-1:0] y_value;

  modport source (output valid, output target_kind, output x_value, output y_value,
                  input ready);
  modport sink   (input valid, input target_kind, input x_value, input y_value,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/acpp_in_stage.sv -----
// Input register of the parser: captures one received word per cycle while it is empty or advance is high.
// Depends on acpp_pkg and acpp_in_if.
`default_nettype none

module acpp_in_stage
  import acpp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  acpp_in_if.sink               in_ch,
  input  wire logic             advance,
  output logic                  valid_o,
  output logic [ByteW-1:0]      byte_o
);

  logic             valid_r, valid_nxt;
  logic [ByteW-1:0] byte_r;
  logic             load;

  assign in_ch.ready = !valid_r || advance;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign valid_o = valid_r;
  assign byte_o  = byte_r;

endmodule

`default_nettype wire

// ----- sv/acpp_parser.sv -----
// Frame parser core: holds the frame state and decodes one byte per step.
// Depends on acpp_pkg and the assertion macro header.
`default_nettype none

`include "ascii_coordinate_packet_parser_top_macros.svh"

module acpp_parser
  import acpp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [ByteW-1:0] rx_byte,
  output logic                  res_valid,
  output result_t               res
);

  logic             in_frame_r, in_frame_nxt;
  logic [1:0]       chars_r, chars_nxt;
  logic [ByteW-1:0] type_r, type_nxt;
  phase_t           phase_r, phase_nxt;
  logic             minus_r, minus_nxt;
  logic [ValW-1:0]  acc_r, acc_nxt;
  logic [ValW-1:0]  first_r, first_nxt;
  logic [ValW-1:0]  second_r, second_nxt;

  logic            is_start, is_end, is_digit, is_sign, is_comma, body;
  logic [ValW-1:0] digit_v, acc_x10, signed_v;
  logic [ValW-1:0] x_raw, y_raw;
  logic [KindW-1:0] kind;

  assign is_start = (rx_byte == CH_START);
  assign is_end   = (rx_byte == CH_END);
  assign is_comma = (rx_byte == CH_COMMA);
  assign is_sign  = (rx_byte == CH_MINUS) || (rx_byte == CH_PLUS);
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit_v  = {{(ValW-4){1'b0}}, rx_byte[3:0]};
  // acc * 10 as two shifts and an add; wraps at 32 bits
  assign acc_x10  = (acc_r << 3) + (acc_r << 1) + digit_v;
  assign signed_v = minus_r ? (~acc_r + 1'b1) : acc_r;

  // ordinary body byte of an open frame
  assign body = step && in_frame_r && !is_start && !is_end;

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    if (step && is_start) begin
      phase_nxt = PH_TYPE;
    end else if (body) begin
      unique case (phase_r)
        PH_TYPE:   phase_nxt = PH_SKIP;
        PH_SKIP:   phase_nxt = PH_XSTART;
        PH_XSTART, PH_XDIG: begin
          if (is_digit || (phase_r == PH_XSTART && is_sign)) begin
            phase_nxt = PH_XDIG;
          end else begin
            phase_nxt = is_comma ? PH_YSTART : PH_DONE;
          end
        end
        PH_YSTART, PH_YDIG: begin
          if (is_digit || (phase_r == PH_YSTART && is_sign)) begin
            phase_nxt = PH_YDIG;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        default:   phase_nxt = phase_r;
      endcase
    end
  end

  // frame state and number accumulation
  always_comb begin
    in_frame_nxt = in_frame_r;
    chars_nxt    = chars_r;
    type_nxt     = type_r;
    minus_nxt    = minus_r;
    acc_nxt      = acc_r;
    first_nxt    = first_r;
    second_nxt   = second_r;
    if (step && is_start) begin
      in_frame_nxt = 1'b1;
      chars_nxt    = 2'd0;
      minus_nxt    = 1'b0;
      acc_nxt      = '0;
      first_nxt    = '0;
      second_nxt   = '0;
    end else if (step && in_frame_r && is_end) begin
      in_frame_nxt = 1'b0;
    end else if (body) begin
      if (chars_r < MIN_BODY) begin
        chars_nxt = chars_r + 2'd1;
      end
      unique case (phase_r)
        PH_TYPE: type_nxt = rx_byte;
        PH_XSTART, PH_YSTART: begin
          minus_nxt = (rx_byte == CH_MINUS);
          acc_nxt   = is_digit ? digit_v : '0;
          if (!is_digit && !is_sign) begin
            if (phase_r == PH_XSTART) begin
              first_nxt = '0;
            end else begin
              second_nxt = '0;
            end
          end
        end
        PH_XDIG, PH_YDIG: begin
          if (is_digit) begin
            acc_nxt = acc_x10;
          end else if (phase_r == PH_XDIG) begin
            first_nxt = signed_v;
          end else begin
            second_nxt = signed_v;
          end
        end
        default: ;
      endcase
    end
  end

  // result on a closing mark
  always_comb begin
    x_raw = first_r;
    y_raw = second_r;
    unique case (phase_r)
      PH_XSTART: begin
        x_raw = '0;
        y_raw = '0;
      end
      PH_XDIG: begin
        x_raw = signed_v;
        y_raw = '0;
      end
      PH_YSTART: y_raw = '0;
      PH_YDIG:   y_raw = signed_v;
      default: ;
    endcase

    if (type_r == TYPE_O) begin
      kind = KIND_CIRCLE;
    end else if (type_r == TYPE_L) begin
      kind = KIND_LASER;
    end else if (type_r == TYPE_C) begin
      kind = KIND_CROSS;
    end else begin
      kind = KIND_NONE;
    end

    res_valid = step && in_frame_r && is_end && (chars_r == MIN_BODY)
                && (kind != KIND_NONE);
    res.kind  = kind;
    if (kind == KIND_CIRCLE) begin
      res.x = x_raw;
      res.y = y_raw;
    end else begin
      res.x = trunc16(x_raw);
      res.y = trunc16(y_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      chars_r    <= 2'd0;
      type_r     <= '0;
      phase_r    <= PH_TYPE;
      minus_r    <= 1'b0;
      acc_r      <= '0;
      first_r    <= '0;
      second_r   <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      chars_r    <= chars_nxt;
      type_r     <= type_nxt;
      phase_r    <= phase_nxt;
      minus_r    <= minus_nxt;
      acc_r      <= acc_nxt;
      first_r    <= first_nxt;
      second_r   <= second_nxt;
    end
  end

  // a start mark always opens a fresh frame at the type byte
  `ACPP_ASSERT(a_start_opens, clk, rst_n, (step && is_start) |=> in_frame_r)
  `ACPP_ASSERT(a_start_count, clk, rst_n, (step && is_start) |=> (chars_r == 2'd0))
  `ACPP_ASSERT(a_start_phase, clk, rst_n, (step && is_start) |=> (phase_r == PH_TYPE))
  // results only come from a frame that was open and now closes
  `ACPP_ASSERT(a_res_closes, clk, rst_n, res_valid |=> !in_frame_r)

endmodule

`default_nettype wire

// ----- sv/acpp_out_fifo.sv -----
// Two-word result buffer that decouples the parser from the result channel.
// Depends on acpp_pkg, acpp_out_if and the assertion macro header.
`default_nettype none

`include "ascii_coordinate_packet_parser_top_macros.svh"

module acpp_out_fifo
  import acpp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  result_t    push_data,
  output logic       full,
  acpp_out_if.source out_ch
);

  localparam int unsigned Depth = 2;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  result_t         mem_r [Depth];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            pop;

  assign full = (cnt_r == CntW'(Depth));
  assign pop  = out_ch.valid && out_ch.ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.target_kind = mem_r[rd_ptr_r].kind;
  assign out_ch.x_value     = mem_r[rd_ptr_r].x;
  assign out_ch.y_value     = mem_r[rd_ptr_r].y;

  // upstream stalls on full, so a word never lands in a full buffer
  `ACPP_ASSERT_NEVER(a_no_overrun, clk, rst_n, push && full)
  // fill level tracks the pointers
  `ACPP_ASSERT(a_cnt_ptrs, clk, rst_n, (cnt_r == CntW'(1)) == (wr_ptr_r != rd_ptr_r))
  `ACPP_ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > CntW'(Depth))

endmodule

`default_nettype wire

// ----- sv/ascii_coordinate_packet_parser_top.sv -----
// Throughput: one byte per cycle; the only stall is a full two-word result buffer.
// Each byte passes the input register, one parser step, then the result buffer.
// Reset: synchronous active-low rst_n clears frame state, buffer and valid flags.
// Depends on acpp_pkg, acpp_if, acpp_in_stage, acpp_parser and acpp_out_fifo.
`default_nettype none

module ascii_coordinate_packet_parser_top
  import acpp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  acpp_in_if.sink    in_ch,
  acpp_out_if.source out_ch
);

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             fifo_full;
  logic             advance;
  logic             res_valid;
  result_t          res;

  assign advance = !fifo_full;

  acpp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .valid_o (s1_valid),
    .byte_o  (s1_byte)
  );

  acpp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_valid && advance),
    .rx_byte   (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  acpp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (fifo_full),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ----- test/ascii_coordinate_packet_parser_top_tb.sv -----
// Self-checking bench for the ASCII coordinate frame parser: directed frames, then random
// frames, broken frames and line noise, under random source/sink idling but for the last third.
// Depends on acpp_pkg, acpp_if and the ascii_coordinate_packet_parser_top RTL.
`default_nettype none

module ascii_coordinate_packet_parser_top_tb;
  import acpp_pkg::*;

  localparam int unsigned DEC_RADIX   = 10;
  localparam int          STALL_LIMIT = 2000;
  localparam int          RAND_BYTES  = 1080;
  localparam int          DRAIN_WAIT  = 8;

  typedef struct {
    string   text;
    bit      typed;
    bit      has_res;
    result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  acpp_in_if  in_ch();
  acpp_out_if out_ch();

  ascii_coordinate_packet_parser_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // parser shadow state
  bit              in_frm;
  logic [1:0]      body_cnt;
  logic [ByteW-1:0] ftype;
  phase_t          phase;
  bit              neg;
  logic [ValW-1:0] acc;
  logic [ValW-1:0] x_num;
  logic [ValW-1:0] y_num;

  result_t  pending_coords[$];
  dir_row_t dir_rows[$];
  int       fail_cnt;
  int       frame_bytes;
  int       idle_run;
  int       src_idle;
  int       snk_idle;
  bit       model_muted;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit is_dec_digit(input logic [ByteW-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [ValW-1:0] signed_mag();
    return neg ? -acc : acc;
  endfunction

  function automatic void open_number(input logic [ByteW-1:0] c, input bit is_x);
    neg = 1'b0;
    acc = '0;
    if (c == CH_MINUS) begin
      neg   = 1'b1;
      phase = is_x ? PH_XDIG : PH_YDIG;
    end else if (c == CH_PLUS) begin
      phase = is_x ? PH_XDIG : PH_YDIG;
    end else if (is_dec_digit(c)) begin
      acc   = ValW'(c - CH_ZERO);
      phase = is_x ? PH_XDIG : PH_YDIG;
    end else if (is_x) begin
      x_num = '0;
      phase = (c == CH_COMMA) ? PH_YSTART : PH_DONE;
    end else begin
      y_num = '0;
      phase = PH_DONE;
    end
  endfunction

  function automatic void feed_digit(input logic [ByteW-1:0] c, input bit is_x);
    if (is_dec_digit(c)) begin
      acc = acc * DEC_RADIX + ValW'(c - CH_ZERO);
    end else if (is_x) begin
      x_num = signed_mag();
      phase = (c == CH_COMMA) ? PH_YSTART : PH_DONE;
    end else begin
      y_num = signed_mag();
      phase = PH_DONE;
    end
  endfunction

  // Advances the shadow parser by one byte; returns 1 when a frame closes with a word.
  function automatic bit step_parser(input logic [ByteW-1:0] c, output result_t r);
    logic [ValW-1:0] xv;
    logic [ValW-1:0] yv;
    r      = '0;
    r.kind = KIND_NONE;
    if (c == CH_START) begin
      in_frm   = 1'b1;
      body_cnt = '0;
      phase    = PH_TYPE;
      neg      = 1'b0;
      acc      = '0;
      x_num    = '0;
      y_num    = '0;
      return 1'b0;
    end
    if (!in_frm) return 1'b0;
    if (c == CH_END) begin
      in_frm = 1'b0;
      if (body_cnt < MIN_BODY) return 1'b0;
      xv = x_num;
      yv = y_num;
      // a number still open at the end mark is finished here
      case (phase)
        PH_XSTART: begin
          xv = '0;
          yv = '0;
        end
        PH_XDIG: begin
          xv = signed_mag();
          yv = '0;
        end
        PH_YSTART: yv = '0;
        PH_YDIG:   yv = signed_mag();
        default: ;
      endcase
      case (ftype)
        TYPE_O:  r.kind = KIND_CIRCLE;
        TYPE_L:  r.kind = KIND_LASER;
        TYPE_C:  r.kind = KIND_CROSS;
        default: return 1'b0;
      endcase
      if (r.kind != KIND_CIRCLE) begin
        xv = {{16{xv[15]}}, xv[15:0]};
        yv = {{16{yv[15]}}, yv[15:0]};
      end
      r.x = xv;
      r.y = yv;
      return 1'b1;
    end
    if (body_cnt < MIN_BODY) body_cnt++;
    case (phase)
      PH_TYPE: begin
        ftype = c;
        phase = PH_SKIP;
      end
      PH_SKIP:   phase = PH_XSTART;
      PH_XSTART: open_number(c, 1'b1);
      PH_XDIG:   feed_digit(c, 1'b1);
      PH_YSTART: open_number(c, 1'b0);
      PH_YDIG:   feed_digit(c, 1'b0);
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Input and output monitor: predicts on every accepted byte, checks every accepted word.
  always @(posedge clk) begin : mon
    result_t got_r;
    result_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (in_frm || in_ch.rx_byte == CH_START) frame_bytes++;
      if (step_parser(in_ch.rx_byte, got_r) && !model_muted) pending_coords.push_back(got_r);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_coords.size() == 0) begin
        $error("unexpected result word: kind %0d x %0d y %0d",
               out_ch.target_kind, out_ch.x_value, out_ch.y_value);
        fail_cnt++;
      end else begin
        want = pending_coords.pop_front();
        if (out_ch.target_kind !== want.kind) begin
          $error("target_kind: expected %0d, got %0d", want.kind, out_ch.target_kind);
          fail_cnt++;
        end
        if (out_ch.x_value !== want.x) begin
          $error("x_value: expected %0d, got %0d", want.x, out_ch.x_value);
          fail_cnt++;
        end
        if (out_ch.y_value !== want.y) begin
          $error("y_value: expected %0d, got %0d", want.y, out_ch.y_value);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_run = 0;
      else idle_run++;
      if (idle_run >= STALL_LIMIT) begin
        $display("ascii_coordinate_packet_parser_top_tb NOT OK");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic [ByteW-1:0] pick_filler();
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom_range(255)); while (b == CH_START || b == CH_END);
    return b;
  endfunction

  function automatic logic [ByteW-1:0] pick_type();
    case ($urandom_range(9))
      0, 1, 2: return TYPE_O;
      3, 4, 5: return TYPE_L;
      6, 7, 8: return TYPE_C;
      default: return pick_filler();
    endcase
  endfunction

  task automatic send_number();
    int ndig;
    case ($urandom_range(3))
      0: send_byte(CH_MINUS);
      1: send_byte(CH_PLUS);
      default: ;
    endcase
    // long runs of digits push the accumulator past 32 bits
    ndig = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6);
    repeat (ndig) send_byte(CH_ZERO + ByteW'($urandom_range(9)));
  endtask

  task automatic send_frame();
    send_byte(CH_START);
    send_byte(pick_type());
    send_byte(pick_filler());
    send_number();
    if ($urandom_range(9) < 7) begin
      send_byte(CH_COMMA);
      send_number();
    end
    if ($urandom_range(99) < 15) repeat ($urandom_range(1, 3)) send_byte(pick_filler());
    send_byte(CH_END);
  endtask

  task automatic send_broken();
    case ($urandom_range(3))
      0: begin
        // frame cut off, the next start mark drops it
        send_byte(CH_START);
        send_byte(pick_type());
        repeat ($urandom_range(0, 4)) send_byte(pick_filler());
      end
      1: begin
        send_byte(CH_START);
        repeat ($urandom_range(0, 2)) send_byte(pick_type());
        send_byte(CH_END);
      end
      2: send_byte(CH_END);
      default: begin
        send_byte(CH_START);
        send_frame();
      end
    endcase
  endtask

  function automatic void add_row(input string t, input bit typed, input bit has_res,
                                  input logic [KindW-1:0] kind, input int x, input int y);
    dir_row_t row;
    row.text    = t;
    row.typed   = typed;
    row.has_res = has_res;
    row.res     = '{kind, x, y};
    dir_rows.push_back(row);
  endfunction

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    rst_n         = 1'b0;
    src_idle      = 28;
    snk_idle      = 48;
    model_muted   = 1'b0;
    fail_cnt      = 0;
    frame_bytes   = 0;
    idle_run      = 0;

    add_row("#",                          1, 0, KIND_NONE,   0,  0);
    add_row("$O?5#",                      1, 1, KIND_CIRCLE, 5,  0);
    add_row("$O?#",                       1, 0, KIND_NONE,   0,  0);
    add_row("$L?-7,+9#",                  1, 1, KIND_LASER,  -7, 9);
    add_row("$C?2147483647,-2147483648#", 0, 0, KIND_NONE,   0,  0);
    add_row("$O?4294967295,-4294967296#", 0, 0, KIND_NONE,   0,  0);
    add_row("$Q?1,2#",                    1, 0, KIND_NONE,   0,  0);
    add_row("$O?-#",                      1, 1, KIND_CIRCLE, 0,  0);
    add_row("$O?12,#",                    1, 1, KIND_CIRCLE, 12, 0);
    add_row("$O?3,4xyz#",                 1, 1, KIND_CIRCLE, 3,  4);
    add_row("$O?1$L?65535,32768#",        0, 0, KIND_NONE,   0,  0);
    add_row("$C\200\3779\377#",           1, 1, KIND_CROSS,  0,  0);
    add_row("$O?,5#",                     1, 1, KIND_CIRCLE, 0,  5);
    add_row("x$O?00042,-0#",              1, 1, KIND_CIRCLE, 42, 0);
    add_row("$L?99999,-1#",               0, 0, KIND_NONE,   0,  0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      model_muted = dir_rows[i].typed;
      for (int k = 0; k < dir_rows[i].text.len(); k++) send_byte(dir_rows[i].text[k]);
      if (dir_rows[i].typed && dir_rows[i].has_res) pending_coords.push_back(dir_rows[i].res);
      model_muted = 1'b0;
    end

    frame_bytes = 0;
    while (frame_bytes < RAND_BYTES) begin
      if (frame_bytes < RAND_BYTES / 3) begin
        src_idle = 28;
        snk_idle = 48;
      end else if (frame_bytes < 2 * RAND_BYTES / 3) begin
        src_idle = 48;
        snk_idle = 28;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      case ($urandom_range(19))
        0, 1:    send_broken();
        2, 3, 4: repeat ($urandom_range(1, 4)) send_byte(ByteW'($urandom_range(255)));
        default: send_frame();
      endcase
    end
    in_ch.valid <= 1'b0;

    while (pending_coords.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("ascii_coordinate_packet_parser_top_tb OK");
    end else begin
      $display("ascii_coordinate_packet_parser_top_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
